@@ design/scv_pkg.sv @@
// ----------------------------------------------------------------------------
// scv_pkg: shared constants, types and helpers of the sample confidence block
// Widths of the interval pipeline, register codes, comparator and verdict
// codes, and the cell records handed along the divider and root chains.
// ----------------------------------------------------------------------------
package scv_pkg;

   // Counts are read in their low SAMPLE_BITS bits
   localparam int SAMPLE_BITS    = 20;
   localparam int COUNT_BITS     = 20;
   localparam int DEPTH_BITS     = 16;
   localparam int ZETA_BITS      = 16;
   localparam int BORDER_BITS    = 17;
   localparam int FRAC_BITS      = 16;

   // Interval arithmetic widths
   localparam int PROD_BITS      = 2 * SAMPLE_BITS;
   localparam int VAR_BITS       = SAMPLE_BITS + FRAC_BITS;
   localparam int ROOT_BITS      = (VAR_BITS + 1) / 2;
   localparam int RADICAND_BITS  = 2 * ROOT_BITS;
   localparam int SPREAD_BITS    = ZETA_BITS + ROOT_BITS;
   localparam int SCALED_BITS    = SAMPLE_BITS + FRAC_BITS;
   localparam int NUM_BITS       = ((SCALED_BITS > SPREAD_BITS) ? SCALED_BITS : SPREAD_BITS) + 1;

   // Transient test widths
   localparam int DEN_BITS       = SAMPLE_BITS + 9;
   localparam int TR_PROD_BITS   = SAMPLE_BITS + DEN_BITS;

   // Pipeline depths
   localparam int SIDE_DEPTH     = VAR_BITS + ROOT_BITS + 2;
   localparam int LANE_DEPTH     = VAR_BITS + ROOT_BITS + 3 + BORDER_BITS;
   localparam int TR_STAGES      = 3;
   localparam int TAIL_DEPTH     = LANE_DEPTH - TR_STAGES + 1;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERVAL_ZETA     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONVERGENCE_ZETA  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROBABILITY_BOUND = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMPARATOR_KIND   = 2'd3;

   localparam logic [ZETA_BITS-1:0]   INTERVAL_ZETA_RESET    = 16'd502;
   localparam logic [ZETA_BITS-1:0]   CONVERGENCE_ZETA_RESET = 16'd256;
   localparam logic [BORDER_BITS-1:0] BOUND_RESET            = 17'd32768;

   localparam logic [BORDER_BITS-1:0] BORDER_ONE  = BORDER_BITS'(1) << FRAC_BITS;
   localparam logic [BORDER_BITS-1:0] BORDER_ZERO = '0;

   // Comparator codes
   localparam logic [1:0] CMP_LE = 2'd0;
   localparam logic [1:0] CMP_LT = 2'd1;
   localparam logic [1:0] CMP_GE = 2'd2;
   localparam logic [1:0] CMP_GT = 2'd3;

   // Verdict codes
   localparam logic [1:0] VERDICT_UNKNOWN = 2'd0;
   localparam logic [1:0] VERDICT_HOLDS   = 2'd1;
   localparam logic [1:0] VERDICT_FAILS   = 2'd2;

   // One restoring division step
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] rem;
      logic [SAMPLE_BITS-1:0] divisor;
      logic [VAR_BITS-1:0]    work;
   } div_cell_type;

   // One digit step of the integer square root
   typedef struct packed {
      logic [ROOT_BITS+1:0]     rem;
      logic [ROOT_BITS-1:0]     root;
      logic [RADICAND_BITS-1:0] work;
   } sqrt_cell_type;

   // Result beat
   typedef struct packed {
      logic [BORDER_BITS-1:0] left_border;
      logic [BORDER_BITS-1:0] right_border;
      logic [1:0]             verdict;
      logic                   in_transient;
      logic                   stat_error;
   } rsp_beat_type;

   // Judge a bound against the interval [lo, hi]
   function automatic logic [1:0] judge_bound(
      input logic [BORDER_BITS-1:0] bound,
      input logic [BORDER_BITS-1:0] lo,
      input logic [BORDER_BITS-1:0] hi,
      input logic [1:0]             kind
   );
      logic holds;
      logic fails;
      holds = 1'b0;
      fails = 1'b0;
      unique case (kind)
         CMP_LE: begin
            holds = bound >= hi;
            fails = bound < lo;
         end
         CMP_LT: begin
            holds = bound > hi;
            fails = bound <= lo;
         end
         CMP_GE: begin
            holds = bound <= lo;
            fails = bound > hi;
         end
         CMP_GT: begin
            holds = bound < lo;
            fails = bound >= hi;
         end
         default: begin
            holds = 1'b0;
            fails = 1'b0;
         end
      endcase
      if (lo > hi) begin
         return VERDICT_UNKNOWN;
      end
      if (holds) begin
         return VERDICT_HOLDS;
      end
      return fails ? VERDICT_FAILS : VERDICT_UNKNOWN;
   endfunction

endpackage

@@ design/scv_req_if.sv @@
// ----------------------------------------------------------------------------
// scv_req_if: sample statistics channel
// Valid/ready channel carrying one sample's size, counts and depth.
// ----------------------------------------------------------------------------
interface scv_req_if import scv_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] obs_count;
   logic [COUNT_BITS-1:0] good_count;
   logic [COUNT_BITS-1:0] transient_count;
   logic [DEPTH_BITS-1:0] sim_depth;

   modport source (
      output valid, obs_count, good_count, transient_count, sim_depth,
      input  ready
   );
   modport sink (
      input  valid, obs_count, good_count, transient_count, sim_depth,
      output ready
   );
endinterface

@@ design/scv_rsp_if.sv @@
// ----------------------------------------------------------------------------
// scv_rsp_if: interval verdict channel
// Valid/ready channel carrying the interval borders, verdict and flags.
// ----------------------------------------------------------------------------
interface scv_rsp_if import scv_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [BORDER_BITS-1:0] left_border;
   logic [BORDER_BITS-1:0] right_border;
   logic [1:0]             verdict;
   logic                   in_transient;
   logic                   stat_error;

   modport source (
      output valid, left_border, right_border, verdict, in_transient, stat_error,
      input  ready
   );
   modport sink (
      input  valid, left_border, right_border, verdict, in_transient, stat_error,
      output ready
   );
endinterface

@@ design/scv_div_cell.sv @@
// ----------------------------------------------------------------------------
// scv_div_cell: one restoring division step
// Shifts the next dividend bit into the remainder, subtracts the divisor
// when it fits and shifts the quotient bit into the work word.
// ----------------------------------------------------------------------------
module scv_div_cell import scv_pkg::*; (
   input  logic         clock,
   input  logic         enable,
   input  div_cell_type feed,
   output div_cell_type cell_out
);

   logic [SAMPLE_BITS:0] trial;
   logic                 fits;
   div_cell_type         cell_in;
   div_cell_type         cell_ff;

   // Trial subtract
   always_comb begin
      trial           = {feed.rem, feed.work[VAR_BITS-1]};
      fits            = trial >= {1'b0, feed.divisor};
      cell_in.divisor = feed.divisor;
      cell_in.rem     = fits ? SAMPLE_BITS'(trial - {1'b0, feed.divisor})
                             : SAMPLE_BITS'(trial);
      cell_in.work    = {feed.work[VAR_BITS-2:0], fits};
   end

   // Advance
   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

@@ design/scv_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// scv_sqrt_cell: one digit step of the integer square root
// Brings down two radicand bits and tests the trial 4*root+1.
// ----------------------------------------------------------------------------
module scv_sqrt_cell import scv_pkg::*; (
   input  logic          clock,
   input  logic          enable,
   input  sqrt_cell_type feed,
   output sqrt_cell_type cell_out
);

   logic [ROOT_BITS+3:0] partial;
   logic [ROOT_BITS+3:0] test;
   logic                 fits;
   sqrt_cell_type        cell_in;
   sqrt_cell_type        cell_ff;

   // Trial subtract of 4*root+1
   always_comb begin
      partial      = {feed.rem, feed.work[RADICAND_BITS-1 -: 2]};
      test         = (ROOT_BITS+4)'({feed.root, 2'b01});
      fits         = partial >= test;
      cell_in.rem  = fits ? (ROOT_BITS+2)'(partial - test) : (ROOT_BITS+2)'(partial);
      cell_in.root = {feed.root[ROOT_BITS-2:0], fits};
      cell_in.work = {feed.work[RADICAND_BITS-3:0], 2'b00};
   end

   // Advance
   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

@@ design/scv_lane.sv @@
// ----------------------------------------------------------------------------
// scv_lane: one interval border
// Variance term x(n-x)/(n-1) through a chain of division cells, its root
// through a chain of root cells, scaling by z, then the border quotient
// through a second division chain with clamping at zero or one.
// ----------------------------------------------------------------------------
module scv_lane import scv_pkg::*; (
   input  logic                   clock,
   input  logic                   enable,
   input  logic                   upper_side,
   input  logic [SAMPLE_BITS-1:0] obs_count,
   input  logic [SAMPLE_BITS-1:0] count,
   input  logic [ZETA_BITS-1:0]   interval_zeta,
   output logic [BORDER_BITS-1:0] border
);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] size;
      logic [SAMPLE_BITS-1:0] count;
   } side_type;

   logic [PROD_BITS-1:0]   prod_ff;
   logic [SAMPLE_BITS-1:0] divisor_ff;
   side_type               side_ff [SIDE_DEPTH];
   logic [SPREAD_BITS-1:0] spread_ff;
   logic [NUM_BITS-1:0]    num_ff;
   logic [SAMPLE_BITS-1:0] size_ff;
   logic                   flag_ff [BORDER_BITS+1];

   div_cell_type           var_feed [VAR_BITS];
   div_cell_type           var_out  [VAR_BITS];
   sqrt_cell_type          root_feed [ROOT_BITS];
   sqrt_cell_type          root_out  [ROOT_BITS];
   div_cell_type           fin_feed [BORDER_BITS];
   div_cell_type           fin_out  [BORDER_BITS];

   side_type               mid;
   logic [NUM_BITS-1:0]    scaled;
   logic [NUM_BITS-1:0]    spread_w;
   logic [NUM_BITS-1:0]    limit;
   logic [NUM_BITS-1:0]    num_in;
   logic                   flag_in;
   logic [BORDER_BITS-1:0] quotient;

   // Product x(n-x) and divisor n-1
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff    <= PROD_BITS'(count) * PROD_BITS'(SAMPLE_BITS'(obs_count - count));
         divisor_ff <= SAMPLE_BITS'(obs_count - SAMPLE_BITS'(1));
      end
   end

   // Carry size and count alongside the chains
   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= '{size: obs_count, count: count};
         for (int i = 1; i < SIDE_DEPTH; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Variance quotient: floor(x(n-x) * 2^16 / (n-1))
   assign var_feed[0] = '{rem:     prod_ff[PROD_BITS-1:SAMPLE_BITS],
                          divisor: divisor_ff,
                          work:    {prod_ff[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}}};

   for (genvar j = 0; j < VAR_BITS; j++) begin : g_var
      if (j > 0) begin : g_link
         assign var_feed[j] = var_out[j-1];
      end
      scv_div_cell u_cell (
         .clock    (clock),
         .enable   (enable),
         .feed     (var_feed[j]),
         .cell_out (var_out[j])
      );
   end

   // Root of the variance term
   assign root_feed[0] = '{rem:  '0,
                           root: '0,
                           work: RADICAND_BITS'(var_out[VAR_BITS-1].work)};

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
      if (j > 0) begin : g_link
         assign root_feed[j] = root_out[j-1];
      end
      scv_sqrt_cell u_cell (
         .clock    (clock),
         .enable   (enable),
         .feed     (root_feed[j]),
         .cell_out (root_out[j])
      );
   end

   // Scale by z
   always_ff @(posedge clock) begin
      if (enable) begin
         spread_ff <= SPREAD_BITS'(interval_zeta) * SPREAD_BITS'(root_out[ROOT_BITS-1].root);
      end
   end

   // Border numerator and clamp flag
   always_comb begin
      mid      = side_ff[SIDE_DEPTH-1];
      scaled   = NUM_BITS'(mid.count) << FRAC_BITS;
      spread_w = NUM_BITS'(spread_ff);
      limit    = (NUM_BITS'(mid.size) << FRAC_BITS) + NUM_BITS'(mid.size);
      if (upper_side) begin
         num_in  = scaled + spread_w;
         flag_in = num_in >= limit;
      end else begin
         num_in  = scaled - spread_w;
         flag_in = spread_w > scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff     <= num_in;
         size_ff    <= mid.size;
         flag_ff[0] <= flag_in;
         for (int i = 1; i <= BORDER_BITS; i++) begin
            flag_ff[i] <= flag_ff[i-1];
         end
      end
   end

   // Border quotient over n
   assign fin_feed[0] = '{rem:     SAMPLE_BITS'(num_ff >> BORDER_BITS),
                          divisor: size_ff,
                          work:    {num_ff[BORDER_BITS-1:0],
                                    {(VAR_BITS-BORDER_BITS){1'b0}}}};

   for (genvar j = 0; j < BORDER_BITS; j++) begin : g_fin
      if (j > 0) begin : g_link
         assign fin_feed[j] = fin_out[j-1];
      end
      scv_div_cell u_cell (
         .clock    (clock),
         .enable   (enable),
         .feed     (fin_feed[j]),
         .cell_out (fin_out[j])
      );
   end

   // Clamp at zero below, one above
   assign quotient = fin_out[BORDER_BITS-1].work[BORDER_BITS-1:0];
   assign border   = flag_ff[BORDER_BITS] ? (upper_side ? BORDER_ONE : BORDER_ZERO)
                                          : quotient;

endmodule

@@ design/sample_confidence_verdict.sv @@
// Throughput: one sample per cycle while the output buffer is not full, set
// by the cell chains of each border lane (36 variance division cells, 18 root
// cells, 17 border division cells).
// A two-entry output buffer lets samples enter while a result waits.
// Reset clears the stage valid bits and the output buffer and loads the
// register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// sample_confidence_verdict: confidence interval and verdict for one sample
// Forms the Wald interval of a sample in two lanes, tests for the transient
// phase and judges the probability bound against the interval.
// ----------------------------------------------------------------------------
module sample_confidence_verdict import scv_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   scv_req_if.sink                   req_chan,
   scv_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] size;
      logic [SAMPLE_BITS-1:0] good;
      logic [SAMPLE_BITS-1:0] trans;
      logic [DEPTH_BITS-1:0]  depth;
   } in_beat_type;

   typedef struct packed {
      logic [DEN_BITS-1:0]    den;
      logic [SAMPLE_BITS-1:0] size;
      logic [SAMPLE_BITS-1:0] trans;
      logic                   depth_zero;
      logic                   size_zero;
      logic                   err;
   } tr1_type;

   typedef struct packed {
      logic [TR_PROD_BITS-1:0] bound_prod;
      logic [TR_PROD_BITS-1:0] count_prod;
      logic                    special;
      logic                    special_val;
      logic                    err;
   } tr2_type;

   typedef struct packed {
      logic err;
      logic transient;
   } tail_type;

   logic [ZETA_BITS-1:0]   interval_zeta_ff;
   logic [ZETA_BITS-1:0]   convergence_zeta_ff;
   logic [BORDER_BITS-1:0] bound_ff;
   logic [1:0]             kind_ff;

   in_beat_type            in_ff;
   logic [LANE_DEPTH:0]    valid_ff;
   tr1_type                tr1_ff;
   tr2_type                tr2_ff;
   tail_type               tail_ff [TAIL_DEPTH];
   rsp_beat_type           slot_ff [2];
   logic [1:0]             occ_ff;
   logic [1:0]             occ_in;

   logic                   advance;
   logic                   push;
   logic                   pop;
   logic [SAMPLE_BITS:0]   good_trans;
   logic                   bad_stats;
   logic [BORDER_BITS-1:0] lane_lo;
   logic [BORDER_BITS-1:0] lane_hi;
   logic [BORDER_BITS-1:0] lo;
   logic [BORDER_BITS-1:0] hi;
   tail_type               last;
   rsp_beat_type           beat_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_zeta_ff    <= INTERVAL_ZETA_RESET;
         convergence_zeta_ff <= CONVERGENCE_ZETA_RESET;
         bound_ff            <= BOUND_RESET;
         kind_ff             <= CMP_LE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INTERVAL_ZETA:     interval_zeta_ff    <= csr_write_data[ZETA_BITS-1:0];
            CSR_CONVERGENCE_ZETA:  convergence_zeta_ff <= csr_write_data[ZETA_BITS-1:0];
            CSR_PROBABILITY_BOUND: bound_ff            <= csr_write_data[BORDER_BITS-1:0];
            CSR_COMPARATOR_KIND:   kind_ff             <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // Whole pipeline moves unless the output buffer is full
   assign advance        = occ_ff != 2'd2;
   assign req_chan.ready = advance;

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LANE_DEPTH-1:0], req_chan.valid};
      end
   end

   // Capture the sample beat
   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff.size  <= SAMPLE_BITS'(req_chan.obs_count);
         in_ff.good  <= SAMPLE_BITS'(req_chan.good_count);
         in_ff.trans <= SAMPLE_BITS'(req_chan.transient_count);
         in_ff.depth <= req_chan.sim_depth;
      end
   end

   // Sanity of the statistics
   assign good_trans = (SAMPLE_BITS+1)'(in_ff.good) + (SAMPLE_BITS+1)'(in_ff.trans);
   assign bad_stats  = (in_ff.size < SAMPLE_BITS'(2)) ||
                       (good_trans > (SAMPLE_BITS+1)'(in_ff.size));

   // Border lanes
   scv_lane u_lane_lo (
      .clock         (clock),
      .enable        (advance),
      .upper_side    (1'b0),
      .obs_count     (in_ff.size),
      .count         (in_ff.good),
      .interval_zeta (interval_zeta_ff),
      .border        (lane_lo)
   );

   scv_lane u_lane_hi (
      .clock         (clock),
      .enable        (advance),
      .upper_side    (1'b1),
      .obs_count     (in_ff.size),
      .count         (good_trans[SAMPLE_BITS-1:0]),
      .interval_zeta (interval_zeta_ff),
      .border        (lane_hi)
   );

   // Transient test: t * (zc + 256(n-1)) > zc * n, with special cases
   always_ff @(posedge clock) begin
      if (advance) begin
         tr1_ff.den        <= DEN_BITS'(convergence_zeta_ff) +
                              (DEN_BITS'(SAMPLE_BITS'(in_ff.size - SAMPLE_BITS'(1))) << 8);
         tr1_ff.size       <= in_ff.size;
         tr1_ff.trans      <= in_ff.trans;
         tr1_ff.depth_zero <= in_ff.depth == '0;
         tr1_ff.size_zero  <= in_ff.size == '0;
         tr1_ff.err        <= bad_stats;

         tr2_ff.bound_prod  <= TR_PROD_BITS'(convergence_zeta_ff) * TR_PROD_BITS'(tr1_ff.size);
         tr2_ff.count_prod  <= TR_PROD_BITS'(tr1_ff.trans) * TR_PROD_BITS'(tr1_ff.den);
         tr2_ff.special     <= tr1_ff.depth_zero || tr1_ff.size_zero || (tr1_ff.den == '0);
         tr2_ff.special_val <= tr1_ff.depth_zero ||
                               (tr1_ff.size_zero ? (tr1_ff.trans != '0) : 1'b1);
         tr2_ff.err         <= tr1_ff.err;
      end
   end

   // Carry flags to the lane outputs
   always_ff @(posedge clock) begin
      if (advance) begin
         tail_ff[0].err       <= tr2_ff.err;
         tail_ff[0].transient <= tr2_ff.special ? tr2_ff.special_val
                                                : (tr2_ff.bound_prod < tr2_ff.count_prod);
         for (int i = 1; i < TAIL_DEPTH; i++) begin
            tail_ff[i] <= tail_ff[i-1];
         end
      end
   end

   // Final borders and verdict
   always_comb begin
      last                 = tail_ff[TAIL_DEPTH-1];
      lo                   = last.err ? BORDER_ZERO : lane_lo;
      hi                   = last.err ? BORDER_ONE  : lane_hi;
      beat_in.left_border  = lo;
      beat_in.right_border = hi;
      beat_in.verdict      = judge_bound(bound_ff, lo, hi, kind_ff);
      beat_in.in_transient = last.transient;
      beat_in.stat_error   = last.err;
   end

   // Output buffer
   assign push   = advance && valid_ff[LANE_DEPTH];
   assign pop    = rsp_chan.valid && rsp_chan.ready;
   assign occ_in = occ_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (occ_ff == 2'd2) begin
            slot_ff[0] <= slot_ff[1];
         end else if (push) begin
            slot_ff[0] <= beat_in;
         end
      end else if (push) begin
         if (occ_ff == 2'd0) begin
            slot_ff[0] <= beat_in;
         end else begin
            slot_ff[1] <= beat_in;
         end
      end
   end

   assign rsp_chan.valid        = occ_ff != 2'd0;
   assign rsp_chan.left_border  = slot_ff[0].left_border;
   assign rsp_chan.right_border = slot_ff[0].right_border;
   assign rsp_chan.verdict      = slot_ff[0].verdict;
   assign rsp_chan.in_transient = slot_ff[0].in_transient;
   assign rsp_chan.stat_error   = slot_ff[0].stat_error;

   // Buffer never overfills
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff != 2'd3)
      else $error("output buffer count out of range");

   // A full, stalled buffer freezes the pipeline
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == 2'd2 && !rsp_chan.ready) |=> $stable(valid_ff))
      else $error("pipeline moved while output buffer full");

   // Bad statistics give the full interval
   a_err_borders: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.stat_error) |->
         (rsp_chan.left_border == BORDER_ZERO && rsp_chan.right_border == BORDER_ONE))
      else $error("error beat without full interval");

   // Right border stays within one
   a_hi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.right_border <= BORDER_ONE)
      else $error("right border above one");

   // Reversed interval gives no verdict
   a_reversed: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.left_border > rsp_chan.right_border) |->
         rsp_chan.verdict == VERDICT_UNKNOWN)
      else $error("verdict on reversed interval");

endmodule

@@ tb/sv/scv_tb_if.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scv_tb_types: testbench types of the sample confidence block
// The sample beat record that the testbench builds and drives.
// ----------------------------------------------------------------------------
package scv_tb_types;
   import scv_pkg::*;

   // One sample beat as the testbench drives it
   typedef struct packed {
      logic [COUNT_BITS-1:0] obs_count;
      logic [COUNT_BITS-1:0] good_count;
      logic [COUNT_BITS-1:0] transient_count;
      logic [DEPTH_BITS-1:0] sim_depth;
   } sample_beat_type;
endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the sample confidence verdict block
// Drives sample beats under several register settings and idle patterns,
// predicts each interval, verdict and flag set, and compares every result
// beat in order against the prediction.
// ----------------------------------------------------------------------------
module tb;
   import scv_pkg::*;
   import scv_tb_types::*;

   localparam int DRAIN_CYCLES = 120;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;

   scv_req_if req_chan ();
   scv_rsp_if rsp_chan ();

   sample_confidence_verdict DUT (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // Predictor copy of the registers
   logic [15:0] z_interval;
   logic [15:0] z_converge;
   logic [16:0] bound_q16;
   logic [1:0]  cmp_kind;

   rsp_beat_type expected_beats[$];
   int mismatch_count = 0;
   bit timed_out = 1'b0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int idle_cycles = 0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.obs_count = '0;
      req_chan.good_count = '0;
      req_chan.transient_count = '0;
      req_chan.sim_depth = '0;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // z times the root of x(n-x)/(n-1), Q.16
   function automatic logic [63:0] spread_of(input logic [63:0] x, input logic [63:0] n);
      logic [63:0] d;
      logic [63:0] p;
      logic [63:0] q;
      d = n - 1;
      p = x * (n - x);
      q = ((p / d) << 16) + (((p % d) << 16) / d);
      return 64'(z_interval) * int_sqrt(q);
   endfunction

   function automatic rsp_beat_type predict_interval(input sample_beat_type s);
      rsp_beat_type r;
      logic [63:0] n, g, t, gt, lo, hi, sl, sr, gl, den;
      logic yes, no;
      n = s.obs_count; g = s.good_count; t = s.transient_count;
      gt = g + t;
      r.stat_error = (n < 2) || (gt > n);
      if (r.stat_error) begin
         lo = 0;
         hi = 65536;
      end else begin
         sl = spread_of(g, n);
         sr = spread_of(gt, n);
         gl = g << 16;
         lo = (sl > gl) ? 64'd0 : (gl - sl) / n;
         hi = ((gt << 16) + sr) / n;
         if (hi > 65536) hi = 65536;
      end
      r.left_border = lo[16:0];
      r.right_border = hi[16:0];
      // Verdict against the bound
      case (cmp_kind)
         CMP_LE: begin yes = bound_q16 >= hi; no = bound_q16 < lo; end
         CMP_LT: begin yes = bound_q16 > hi; no = bound_q16 <= lo; end
         CMP_GE: begin yes = bound_q16 <= lo; no = bound_q16 > hi; end
         default: begin yes = bound_q16 < lo; no = bound_q16 >= hi; end
      endcase
      if (lo > hi) r.verdict = VERDICT_UNKNOWN;
      else if (yes) r.verdict = VERDICT_HOLDS;
      else r.verdict = no ? VERDICT_FAILS : VERDICT_UNKNOWN;
      // Transient test with an integer division
      if (s.sim_depth == 0) r.in_transient = 1'b1;
      else if (n == 0) r.in_transient = t > 0;
      else begin
         den = 64'(z_converge) + 256 * (n - 1);
         if (den == 0) r.in_transient = 1'b1;
         else r.in_transient = t > (64'(z_converge) * n) / den;
      end
      return r;
   endfunction

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx, input int value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_INTERVAL_ZETA: z_interval = value[15:0];
         CSR_CONVERGENCE_ZETA: z_converge = value[15:0];
         CSR_PROBABILITY_BOUND: bound_q16 = value[16:0];
         default: cmp_kind = value[1:0];
      endcase
   endtask

   task automatic set_registers(input int zi, input int zc, input int b, input int k);
      write_register(CSR_INTERVAL_ZETA, zi);
      write_register(CSR_CONVERGENCE_ZETA, zc);
      write_register(CSR_PROBABILITY_BOUND, b);
      write_register(CSR_COMPARATOR_KIND, k);
   endtask

   // Send one sample beat; keep valid high for back-to-back beats
   task automatic send_sample(input sample_beat_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.obs_count <= s.obs_count;
      req_chan.good_count <= s.good_count;
      req_chan.transient_count <= s.transient_count;
      req_chan.sim_depth <= s.sim_depth;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_beats.push_back(predict_interval(s));
   endtask

   task automatic end_burst();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_beats.size() != 0 && !timed_out) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic sample_beat_type make_sample(input int n, input int g, input int t,
                                                   input int d);
      sample_beat_type s;
      s.obs_count = n[19:0];
      s.good_count = g[19:0];
      s.transient_count = t[19:0];
      s.sim_depth = d[15:0];
      return s;
   endfunction

   // Mostly well-formed samples, small and large, with some bad statistics
   function automatic sample_beat_type random_sample();
      int n, g, t, sel;
      sel = $urandom_range(99);
      if (sel < 10) return make_sample($urandom, $urandom, $urandom, $urandom);
      if (sel < 50) n = $urandom_range(2, 64);
      else if (sel < 80) n = $urandom_range(2, 4096);
      else n = $urandom_range(2, 1048575);
      g = $urandom_range(0, n);
      t = $urandom_range(0, n - g);
      if (sel < 14) t = $urandom_range(0, 3);
      return make_sample(n, g, t, ($urandom_range(9) == 0) ? 0 : $urandom_range(65535));
   endfunction

   // Receiver stalls and result check
   always @(posedge clock) begin
      rsp_beat_type exp_beat;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_beats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result beat");
            end else begin
               exp_beat = expected_beats.pop_front();
               if (exp_beat.left_border !== rsp_chan.left_border ||
                   exp_beat.right_border !== rsp_chan.right_border ||
                   exp_beat.verdict !== rsp_chan.verdict ||
                   exp_beat.in_transient !== rsp_chan.in_transient ||
                   exp_beat.stat_error !== rsp_chan.stat_error) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("mismatch: expected L=%0d R=%0d V=%0d T=%0b E=%0b",
                            exp_beat.left_border, exp_beat.right_border, exp_beat.verdict,
                            exp_beat.in_transient, exp_beat.stat_error);
                     $display(" got L=%0d R=%0d V=%0d T=%0b E=%0b",
                              rsp_chan.left_border, rsp_chan.right_border, rsp_chan.verdict,
                              rsp_chan.in_transient, rsp_chan.stat_error);
                  end
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("CHECK FAILED");
            timed_out = 1'b1;
            $finish;
         end
      end
   end

   task automatic test_reset_defaults();
      z_interval = INTERVAL_ZETA_RESET;
      z_converge = CONVERGENCE_ZETA_RESET;
      bound_q16 = BOUND_RESET;
      cmp_kind = CMP_LE;
      send_sample(make_sample(100, 50, 0, 10));
      send_sample(make_sample(10, 3, 2, 5));
      end_burst();
      wait_drained();
   endtask

   task automatic test_directed_cases();
      int k;
      for (k = 0; k < 4; k++) begin
         set_registers(k == 0 ? 0 : (k == 1 ? 65535 : 502), k == 2 ? 0 : (k == 3 ? 65535 : 256),
                       k == 0 ? 0 : (k == 1 ? 65536 : (k == 2 ? 131071 : 40000)), k);
         send_sample(make_sample(0, 0, 0, 1));                   // empty sample
         send_sample(make_sample(0, 0, 1, 1));
         send_sample(make_sample(1, 0, 1, 7));                   // size one
         send_sample(make_sample(2, 2, 0, 65535));
         send_sample(make_sample(10, 6, 5, 3));                  // counts over size
         send_sample(make_sample(1048575, 1048575, 0, 0));       // depth zero
         send_sample(make_sample(1048575, 0, 1048575, 1));
         send_sample(make_sample(1048575, 524287, 524288, 100));
         send_sample(make_sample(1048575, 1048575, 1048575, 9));
         send_sample(make_sample(5, 0, 0, 2));
         send_sample(make_sample(5, 5, 0, 2));
         end_burst();
         wait_drained();
      end
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
      int i;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      set_registers($urandom_range(65535), $urandom_range(256, 65535),
                    $urandom_range(131071) < 16000 ? $urandom_range(131071)
                                                    : $urandom_range(65536),
                    $urandom_range(3));
      for (i = 0; i < count; i++) begin
         if ($urandom_range(7) == 0) begin
            z_interval = z_interval; // register stays; vary burst only
         end
         send_sample(random_sample());
         if ($urandom_range(40) == 0) end_burst();
      end
      end_burst();
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_cases();
      repeat (2) begin
         test_random_phase(0, 0, 160);
         test_random_phase(68, 0, 150);
         test_random_phase(0, 68, 150);
         test_random_phase(19, 19, 150);
      end
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

@@ sample_confidence_verdict.f @@
design/scv_pkg.sv
design/scv_req_if.sv
design/scv_rsp_if.sv
design/scv_div_cell.sv
design/scv_sqrt_cell.sv
design/scv_lane.sv
design/sample_confidence_verdict.sv
tb/sv/scv_tb_if.sv
tb/sv/tb.sv
